// ===== rtl/core/stip_pkg.sv =====
package stip_pkg;

  localparam int unsigned MAX_LEN_DEFAULT = 255;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BASE_W     = 6;
  localparam int unsigned DIGIT_W    = 6;

  // Register indexes, taken from the word address.
  localparam logic REG_NUMBER_BASE = 1'b0;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;

  localparam logic [DIGIT_W-1:0] NOT_A_DIGIT = 6'd36;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_DIGITS = 2'd1,
    STATUS_BAD_BASE  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] parsed_value;
    logic [7:0]         consumed_count;
    status_t            status;
  } out_item_t;

  function automatic logic is_white(input logic [7:0] c);
    is_white = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Digit value 0 to 35, or NOT_A_DIGIT for any other byte.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(NOT_A_DIGIT);
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      d = c - CH_ZERO;
    end else if ((c >= CH_LO_A) && (c <= CH_LO_Z)) begin
      d = c - CH_LO_A + 8'd10;
    end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
      d = c - CH_UP_A + 8'd10;
    end
    digit_of = d[DIGIT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/stip_cfg_regs.sv =====
module stip_cfg_regs
  import stip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic [BASE_W-1:0]     number_base
);

  logic [BASE_W-1:0] number_base_r;
  logic              wr_en;
  logic              reg_sel;

  // Word index; the low two address bits are not decoded.
  assign reg_sel = paddr[CFG_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && (reg_sel == REG_NUMBER_BASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_RESET;
    end else if (wr_en) begin
      number_base_r <= pwdata[BASE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_NUMBER_BASE) begin
      prdata = {{(CFG_DATA_W-BASE_W){1'b0}}, number_base_r};
    end
  end

  assign number_base = number_base_r;

endmodule

// ===== rtl/core/stip_parse_engine.sv =====
module stip_parse_engine
  import stip_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  in_item_t          item,
  input  logic [BASE_W-1:0] number_base,
  output out_item_t         result
);

  localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

  typedef enum logic [2:0] {
    PH_START,
    PH_SKIP,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE,
    PH_INVALID
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  endp_r, endp_nxt;
  logic              seen_r, seen_nxt;

  logic [POS_W-1:0]   pos_inc;
  logic               taken;
  logic [7:0]         c;
  logic [DIGIT_W-1:0] dval;
  logic [POS_W+7:0]   endp_ext;
  logic [31:0]        value;

  assign c       = item.char_code;
  assign dval    = digit_of(c);
  assign pos_inc = (pos_r >= POS_MAX) ? POS_MAX : pos_r + 1'b1;

  // One character can walk through more than one phase in the same cycle:
  // start to white space to sign to digits, or the zero prefix to digits.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    endp_nxt  = endp_r;
    seen_nxt  = seen_r;
    taken     = 1'b0;

    if (phase_nxt == PH_START) begin
      if ((number_base == BASE_ONE) || (number_base > BASE_MAX)) begin
        phase_nxt = PH_INVALID;
      end else begin
        base_nxt  = number_base;
        phase_nxt = PH_SKIP;
      end
    end

    if (phase_nxt == PH_SKIP) begin
      if (is_white(c)) begin
        taken = 1'b1;
      end else begin
        phase_nxt = PH_SIGNED;
        if (c == CH_PLUS) begin
          taken = 1'b1;
        end else if (c == CH_MINUS) begin
          neg_nxt = 1'b1;
          taken   = 1'b1;
        end
      end
    end

    if (!taken && (phase_nxt == PH_SIGNED)) begin
      if ((c == CH_ZERO) && ((base_nxt == BASE_AUTO) || (base_nxt == BASE_HEX))) begin
        seen_nxt  = 1'b1;
        endp_nxt  = pos_inc;
        phase_nxt = PH_ZERO;
        taken     = 1'b1;
      end else begin
        if (base_nxt == BASE_AUTO) begin
          base_nxt = BASE_DEC;
        end
        phase_nxt = PH_DIGITS;
      end
    end

    if (!taken && (phase_nxt == PH_ZERO)) begin
      if ((c == CH_LO_X) || (c == CH_UP_X)) begin
        base_nxt  = BASE_HEX;
        phase_nxt = PH_DIGITS;
        taken     = 1'b1;
      end else begin
        if (base_nxt == BASE_AUTO) begin
          base_nxt = BASE_OCT;
        end
        phase_nxt = PH_DIGITS;
      end
    end

    if (!taken && (phase_nxt == PH_DIGITS)) begin
      if (dval < base_nxt) begin
        acc_nxt  = (acc_r * 32'(base_nxt)) + 32'(dval);
        seen_nxt = 1'b1;
        endp_nxt = pos_inc;
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  assign pos_nxt = pos_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      base_r  <= '0;
      pos_r   <= '0;
      endp_r  <= '0;
      seen_r  <= 1'b0;
    end else if (step_en) begin
      if (item.end_of_string) begin
        phase_r <= PH_START;
        neg_r   <= 1'b0;
        acc_r   <= '0;
        base_r  <= '0;
        pos_r   <= '0;
        endp_r  <= '0;
        seen_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
        base_r  <= base_nxt;
        pos_r   <= pos_nxt;
        endp_r  <= endp_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  assign endp_ext = {8'b0, endp_nxt};
  assign value    = neg_nxt ? (32'd0 - acc_nxt) : acc_nxt;

  always_comb begin
    result = '0;
    if (phase_nxt == PH_INVALID) begin
      result.status = STATUS_BAD_BASE;
    end else if (!seen_nxt) begin
      result.status = STATUS_NO_DIGITS;
    end else begin
      result.parsed_value   = value;
      result.consumed_count = endp_ext[7:0];
      result.status         = STATUS_OK;
    end
  end

endmodule

// ===== rtl/core/string_to_integer_parser_core.sv =====
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_ready   in_item_t: char_code, end_of_string
// out_     output     out_valid/out_ready out_item_t: parsed_value, consumed_count, status
// cfg_     APB slave  psel/penable/pready register 0 at byte 0: number_base
//
// Sustained rate is one character per cycle while no final character waits on a
// stalled result; the per-character step, a 32 by 6 bit multiply-add plus phase
// decode, is combinational; each result is registered in the output register.
// Reset is synchronous and active low; it clears the parse state, both
// pipeline valids and sets number_base to 10.
// A stalled result holds in the output register while later characters
// keep flowing as long as no second end of string needs that register.
module string_to_integer_parser_core
  import stip_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,

  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // Input register: holds one character until the parse step takes it.
  in_item_t  in_data_r;
  logic      in_valid_r;

  // Output register: holds one finished result until it is taken.
  out_item_t out_data_r;
  logic      out_valid_r;

  logic              advance;
  logic              out_free;
  logic [BASE_W-1:0] number_base;
  out_item_t         step_result;

  stip_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .number_base (number_base)
  );

  assign cfg_pready = 1'b1;

  // A character that does not end the string never needs the output
  // register, so only the final character can wait on a stalled result.
  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && (!in_data_r.end_of_string || out_free);
  assign in_ready = !in_valid_r || advance;

  stip_parse_engine #(
    .MAX_LEN (MAX_LEN)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .item        (in_data_r),
    .number_base (number_base),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_data_r.end_of_string) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_data_r.end_of_string) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/stip_checker.sv =====
module stip_checker
  import stip_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STATUS_OK)
      |-> (out_data.parsed_value == 32'sd0) && (out_data.consumed_count == 8'd0))
    else $error("error result carries a value or count");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_OK) |-> (out_data.consumed_count != 8'd0))
    else $error("successful parse with zero consumed count");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port inserted a wait state");

endmodule

bind string_to_integer_parser_core stip_checker u_stip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stip_pkg::*;

  // The block's own string length limit, shared by the instance and the predictor.
  localparam int unsigned STR_LIMIT = MAX_LEN_DEFAULT;

  // Radix settings used by the stimulus beyond those that the package names.
  localparam logic [BASE_W-1:0] BASE_BINARY = 6'd2;
  localparam logic [BASE_W-1:0] BASE_TOP    = 6'd63;

  // A result passes the input and output registers after its final character is taken.
  // Settle then waits SETTLE_CYCLES more before touching the radix or ending the run.
  localparam int unsigned SETTLE_CYCLES = 8;

  // The run stops once this many characters have been sent. The count
  // includes the directed strings and one very long string.
  localparam int unsigned CHAR_TARGET = 450;
  // The last stretch of the run is sent and received without any idling.
  localparam int unsigned CALM_TAIL   = 80;

  // Scanning phases of one string, as the predictor tracks them.
  typedef enum logic [2:0] {
    AT_START,
    IN_BLANKS,
    AFTER_SIGN,
    AFTER_ZERO,
    IN_DIGITS,
    PAST_NUMBER,
    BAD_RADIX
  } scan_phase_t;

  // Predicts the parse of each string from the characters that the block
  // accepts, and checks the block's results against those predictions in order.
  class radix_parse_book;
    logic [BASE_W-1:0] base_setting;
    scan_phase_t       phase;
    logic              negative;
    logic [31:0]       acc;
    logic [BASE_W-1:0] radix;
    int unsigned       position;
    int unsigned       last_digit_pos;
    logic              seen_digit;
    out_item_t         awaited_parses[$];
    int unsigned       mismatch_count;

    function new();
      base_setting   = BASE_RESET;
      mismatch_count = 0;
      restart_scan();
    endfunction

    function void restart_scan();
      phase          = AT_START;
      negative       = 1'b0;
      acc            = '0;
      radix          = '0;
      position       = 0;
      last_digit_pos = 0;
      seen_digit     = 1'b0;
    endfunction

    function void set_base(logic [BASE_W-1:0] value);
      base_setting = value;
    endfunction

    function int unsigned outstanding();
      return awaited_parses.size();
    endfunction

    function int unsigned advance(int unsigned p);
      return (p >= STR_LIMIT) ? STR_LIMIT : p + 1;
    endfunction

    function logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Letters are folded to lower case by setting bit 5; only upper-case
    // letters land in the lower-case range that way.
    function logic [DIGIT_W-1:0] char_digit(logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      if ((c >= CH_ZERO) && (c <= CH_NINE)) return DIGIT_W'(c - CH_ZERO);
      if ((folded >= CH_LO_A) && (folded <= CH_LO_Z)) return DIGIT_W'(folded - CH_LO_A + 10);
      return NOT_A_DIGIT;
    endfunction

    // One character may pass through several phases, for example the first
    // digit after the blanks, so the phase machine runs until it settles.
    function void scan_char(logic [7:0] c);
      bit again;
      logic [DIGIT_W-1:0] d;
      again = 1'b1;
      while (again) begin
        again = 1'b0;
        case (phase)
          IN_BLANKS: begin
            if (!is_blank(c)) begin
              phase = AFTER_SIGN;
              if (c == CH_MINUS) begin
                negative = 1'b1;
              end else if (c != CH_PLUS) begin
                again = 1'b1;
              end
            end
          end
          AFTER_SIGN: begin
            if ((c == CH_ZERO) && ((radix == BASE_AUTO) || (radix == BASE_HEX))) begin
              seen_digit     = 1'b1;
              last_digit_pos = advance(position);
              phase          = AFTER_ZERO;
            end else begin
              if (radix == BASE_AUTO) radix = BASE_DEC;
              phase = IN_DIGITS;
              again = 1'b1;
            end
          end
          AFTER_ZERO: begin
            if ((c == CH_LO_X) || (c == CH_UP_X)) begin
              radix = BASE_HEX;
              phase = IN_DIGITS;
            end else begin
              if (radix == BASE_AUTO) radix = BASE_OCT;
              phase = IN_DIGITS;
              again = 1'b1;
            end
          end
          IN_DIGITS: begin
            d = char_digit(c);
            if (d < radix) begin
              acc            = acc * 32'(radix) + 32'(d);
              seen_digit     = 1'b1;
              last_digit_pos = advance(position);
            end else begin
              phase = PAST_NUMBER;
            end
          end
          default: ;
        endcase
      end
    endfunction

    function void note_char(in_item_t item);
      out_item_t parse;
      if (phase == AT_START) begin
        if ((base_setting == BASE_ONE) || (base_setting > BASE_MAX)) begin
          phase = BAD_RADIX;
        end else begin
          radix = base_setting;
          phase = IN_BLANKS;
        end
      end
      scan_char(item.char_code);
      position = advance(position);
      if (item.end_of_string) begin
        if (phase == BAD_RADIX) begin
          parse.parsed_value   = '0;
          parse.consumed_count = '0;
          parse.status         = STATUS_BAD_BASE;
        end else if (!seen_digit) begin
          parse.parsed_value   = '0;
          parse.consumed_count = '0;
          parse.status         = STATUS_NO_DIGITS;
        end else begin
          parse.parsed_value   = negative ? 32'(0) - acc : acc;
          parse.consumed_count = 8'(last_digit_pos);
          parse.status         = STATUS_OK;
        end
        awaited_parses.push_back(parse);
        restart_scan();
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_parses.size() == 0) begin
        $error("unexpected result: parsed_value %0d, consumed_count %0d, status %0d",
               got.parsed_value, got.consumed_count, got.status);
        mismatch_count++;
        return;
      end
      want = awaited_parses.pop_front();
      if (got.parsed_value !== want.parsed_value) begin
        $error("parsed_value: expected %0d, got %0d", want.parsed_value, got.parsed_value);
        mismatch_count++;
      end
      if (got.consumed_count !== want.consumed_count) begin
        $error("consumed_count: expected %0d, got %0d",
               want.consumed_count, got.consumed_count);
        mismatch_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatch_count++;
      end
    endfunction
  endclass

  // Every input of the block holds a known value from time zero on.
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  in_item_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  radix_parse_book book = new();

  // Bytes of the string that is about to be sent.
  logic [7:0]  text_bytes[$];
  int unsigned chars_sent    = 0;
  int unsigned steady_chars  = 0;
  // Once set, neither side idles any more.
  bit          calm          = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  string_to_integer_parser_core #(
    .MAX_LEN(STR_LIMIT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // All block outputs change on nonblocking updates, so reading them right
  // after the rising edge gives the values that the edge itself sampled.
  // A result transaction is checked at the edge where valid and ready meet.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      book.check_result(out_data);
    end
  end

  // The result side holds ready high most of the time, drops it for random bursts,
  // and now and then keeps it high for a long stretch.
  initial begin : result_taker
    int unsigned steady;
    steady = 0;
    forever begin
      @(posedge clk);
      if (calm || (steady > 0) || ($urandom_range(0, 5) != 0)) begin
        out_ready <= 1'b1;
        if (steady > 0) begin
          steady--;
        end else if ($urandom_range(0, 39) == 0) begin
          steady = $urandom_range(20, 60);
        end
      end else begin
        // Ready stays low for the wait below plus the edge at the loop top.
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
    end
  end

  // Offers one character and holds it until the block takes the transaction.
  task automatic send_char(input logic [7:0] code, input logic last);
    in_item_t item;
    item.char_code     = code;
    item.end_of_string = last;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    book.note_char(item);
    chars_sent++;
  endtask

  // Between characters the sender sometimes idles with in_valid low,
  // except inside a steady stretch or in the calm tail of the run.
  task automatic sender_gap();
    if (steady_chars > 0) begin
      steady_chars--;
    end else if ($urandom_range(0, 29) == 0) begin
      steady_chars = $urandom_range(10, 40);
    end else if (!calm && ($urandom_range(0, 3) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Sends the prepared bytes as one string; the last byte carries the end flag.
  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_char(text_bytes[i], i == text_bytes.size() - 1);
      sender_gap();
    end
  endtask

  task automatic send_string(input string s);
    text_bytes.delete();
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
    send_text();
  endtask

  // Lets every pending result drain and the pipeline go quiet, so that the
  // radix register can be written or the run can end.
  task automatic settle();
    in_valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where the access phase meets pready.
  task automatic write_base(input logic [BASE_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_NUMBER_BASE, 2'b00};
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    book.set_base(value);
  endtask

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 5) == 5) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  // Character for a digit value, with letters in either case.
  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(v - 10);
  endfunction

  // Most strings are well formed: blanks, a sign, a prefix where the radix
  // allows one, and digits that fit the radix, then possibly some trailing
  // bytes. A string with no digits is a broken one; a fifth are pure noise.
  task automatic build_text(input logic [BASE_W-1:0] base);
    int unsigned span;
    text_bytes.delete();
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 8)) text_bytes.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 2)) text_bytes.push_back(blank_char());
    case ($urandom_range(0, 3))
      0: text_bytes.push_back(CH_PLUS);
      1: text_bytes.push_back(CH_MINUS);
      default: ;
    endcase
    span = ((base >= BASE_BINARY) && (base <= BASE_MAX)) ? base : BASE_DEC;
    if ((base == BASE_AUTO) || (base == BASE_HEX)) begin
      case ($urandom_range(0, 3))
        0: begin
          text_bytes.push_back(CH_ZERO);
          text_bytes.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
          span = BASE_HEX;
        end
        1: begin
          text_bytes.push_back(CH_ZERO);
          if (base == BASE_AUTO) span = BASE_OCT;
        end
        default: ;
      endcase
    end
    repeat ($urandom_range(0, 11)) text_bytes.push_back(digit_char($urandom_range(0, span - 1)));
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom));
    end
    if (text_bytes.size() == 0) text_bytes.push_back(8'($urandom));
  endtask

  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0: return BASE_AUTO;
      1: return BASE_HEX;
      2: return BASE_DEC;
      3: return BASE_OCT;
      4: return BASE_BINARY;
      5: return BASE_MAX;
      6: begin
        case ($urandom_range(0, 2))
          0: return BASE_ONE;
          1: return BASE_MAX + 6'd1;
          default: return BASE_W'($urandom_range(BASE_MAX + 1, BASE_TOP));
        endcase
      end
      default: return BASE_W'($urandom_range(BASE_BINARY, BASE_MAX));
    endcase
  endfunction

  initial begin : stimulus
    logic [BASE_W-1:0] base;
    int unsigned       phase_no;
    int unsigned       phase_end;

    // Reset is held low from time zero and then released for good.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings in the reset radix of ten: blanks and a minus sign,
    // the highest and the lowest byte as lone non-digits, and a sign alone.
    send_string(" \t-42");
    text_bytes = '{8'hFF};
    send_text();
    text_bytes = '{8'h00};
    send_text();
    send_string("+");

    // Automatic radix: the hex prefix with mixed case, an octal prefix, a
    // leading zero followed by a digit octal cannot take, a lone zero, and a
    // hex prefix with no hex digit after it.
    settle();
    write_base(BASE_AUTO);
    send_string("0X1f");
    send_string("017");
    send_string("08");
    send_string("0");
    send_string("0xg");

    // A radix of one is refused, and the top radix takes letters as digits.
    settle();
    write_base(BASE_ONE);
    send_string("7");
    settle();
    write_base(BASE_MAX);
    send_string("zZ");

    // Random part, in phases with one radix each. The first phase starts
    // with one string long enough to saturate the position counters, and its
    // digits in the top radix also wrap the accumulator.
    phase_no = 0;
    while (chars_sent < CHAR_TARGET) begin
      settle();
      case (phase_no)
        0: base = BASE_MAX;
        1: base = BASE_TOP;
        default: base = pick_base();
      endcase
      write_base(base);
      if (phase_no == 0) begin
        text_bytes.delete();
        repeat ($urandom_range(248, 252)) text_bytes.push_back(blank_char());
        repeat (12) text_bytes.push_back(digit_char($urandom_range(0, BASE_MAX - 1)));
        send_text();
      end
      phase_end = chars_sent + $urandom_range(25, 70);
      // Once the calm tail begins, the phase runs on to the end of the run so
      // that no radix change breaks the gapless stretch.
      while ((chars_sent < CHAR_TARGET) && (calm || (chars_sent < phase_end))) begin
        if (chars_sent + CALM_TAIL >= CHAR_TARGET) calm = 1'b1;
        build_text(base);
        send_text();
      end
      phase_no++;
    end

    // Drain everything still in flight, then give the verdict.
    settle();
    if (book.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/stip_pkg.sv
rtl/core/stip_cfg_regs.sv
rtl/core/stip_parse_engine.sv
rtl/core/string_to_integer_parser_core.sv
rtl/core/stip_checker.sv
tb/tb.sv
